[rtl/core/weighted_rtt_mean_deviation_unit_defines.svh]
// ----------------------------------------------------------------------------
// weighted rtt mean/deviation unit: assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RTT_MEAN_DEVIATION_UNIT_DEFINES_SVH
`define WEIGHTED_RTT_MEAN_DEVIATION_UNIT_DEFINES_SVH

// condition in this cycle implies consequence in the next cycle
`define WRMD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// condition implies consequence in the same cycle
`define WRMD_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

`endif

[rtl/core/wrmd_pkg.sv]
// ----------------------------------------------------------------------------
// wrmd_pkg
// types, constants and datapath command codes of the rtt mean/deviation unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wrmd_pkg;

  localparam int RING_DEPTH_DEF = 64;
  localparam int TIME_W         = 16;
  localparam int WEIGHT_W       = 10;
  localparam int WEIGHT_NUM     = 1023;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic        op;
    logic [31:0] time_rt;
    logic [15:0] attempts;
  } sample_t;

  typedef struct packed {
    logic [15:0] mean_time;
    logic [15:0] deviation;
  } result_t;

  localparam logic OP_INIT = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]   rtt;
    logic [WEIGHT_W-1:0] weight;
  } ring_entry_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_INIT_MUL,
    DP_INIT_WR,
    DP_READ,
    DP_NEW_W,
    DP_MUL_OLD1,
    DP_MUL_OLD2,
    DP_MUL_NEW1,
    DP_MUL_NEW2,
    DP_ACC_SQ,
    DP_DIV_MEAN,
    DP_SET_MEAN,
    DP_MUL_MEAN,
    DP_DIV_VAR,
    DP_DEV_ZERO,
    DP_SQRT,
    DP_SET_DEV,
    DP_OUTPUT
  } dp_op_t;

  typedef struct packed {
    logic op_add;
    logic tries_zero;
    logic wt_gt1;
    logic div_busy;
    logic sqrt_busy;
  } dp_status_t;

endpackage

[rtl/core/weighted_rtt_mean_deviation_unit.sv]
// full add at depth 64: 10-step weight division, 32-step mean division and,
//   when the total weight exceeds one, 48-step variance division and 24-step
//   root; the divisions share one serial divider, the root has its own unit
// one item at a time: the input stalls while an item is in work; a finished
//   beat waits in the output register while the next item is already taken
// reset: synchronous, clears ring valid bits, totals, mean and deviation at once
// ----------------------------------------------------------------------------
// weighted_rtt_mean_deviation_unit
// weighted sliding-window mean and standard deviation of round-trip times
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_rtt_mean_deviation_unit
  import wrmd_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  // sample channel
  input  logic    sample_valid,
  output logic    sample_stall,
  input  sample_t sample,
  // result channel
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  // command from the sequencer, one datapath step per cycle, or a nop while it waits
  dp_op_t     op;
  // busy flags and item decode back from the datapath
  dp_status_t status;

  // sequencer: an idle cycle takes a beat, then walks init or add steps,
  // and parks in its last state until the result register is free
  wrmd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .result_stall (result_stall),
    .status       (status),
    .op           (op),
    .sample_stall (sample_stall),
    .result_valid (result_valid)
  );

  // datapath: ring memory with per-entry valid bits (an invalid entry reads
  // as weight 0), weight / time / square totals, a 16 x 32 multiplier and
  // the shared serial divider and square root
  wrmd_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .sample (sample),
    .status (status),
    .result (result)
  );

endmodule

[rtl/core/wrmd_divider.sv]
// ----------------------------------------------------------------------------
// wrmd_divider
// restoring divider, one quotient bit per cycle, msb-aligned dividend
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrmd_divider
  import wrmd_pkg::*;
#(
  parameter int NW = 48,
  parameter int DW = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NW-1:0]             dividend,
  input  logic [DW-1:0]             divisor,
  input  logic [$clog2(NW+1)-1:0]   steps,
  output logic                      busy,
  output logic [NW-1:0]             quotient
);

  localparam int CW = $clog2(NW+1);

  logic [CW-1:0] count;
  logic [NW-1:0] dvd;
  logic [DW-1:0] dvs;
  logic [DW-1:0] rem;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign busy   = (count != '0);
  assign rem_sh = {rem, dvd[NW-1]};
  assign ge     = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= steps;
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= dvd << 1;
      rem      <= ge ? DW'(rem_sh - {1'b0, dvs}) : rem_sh[DW-1:0];
      quotient <= {quotient[NW-2:0], ge};
    end
  end

endmodule

[rtl/core/wrmd_sqrt.sv]
// ----------------------------------------------------------------------------
// wrmd_sqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrmd_sqrt
  import wrmd_pkg::*;
#(
  parameter int XW = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [XW-1:0]         radicand,
  output logic                  busy,
  output logic [(XW+1)/2-1:0]   root
);

  localparam int RW = (XW + 1) / 2;
  localparam int CW = $clog2(RW + 1);

  logic [CW-1:0]   count;
  logic [2*RW-1:0] xs;
  logic [RW-1:0]   rem;
  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;
  logic            ge;

  assign busy   = (count != '0);
  assign rem_sh = {rem, xs[2*RW-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CW'(RW);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  // the remainder stays at most 2 * root, so it fits until the last step
  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= (2*RW)'(radicand);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      xs   <= xs << 2;
      rem  <= ge ? RW'(rem_sh - trial) : rem_sh[RW-1:0];
      root <= {root[RW-2:0], ge};
    end
  end

endmodule

[rtl/core/wrmd_datapath.sv]
// ----------------------------------------------------------------------------
// wrmd_datapath
// sample ring, running totals, shared multiplier, divider and square root
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrmd_datapath
  import wrmd_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_op_t     op,
  input  sample_t    sample,
  output dp_status_t status,
  output result_t    result
);

  localparam int SW   = $clog2(RING_DEPTH);
  localparam int WTW  = WEIGHT_W + $clog2(RING_DEPTH);
  localparam int WTTW = WTW + TIME_W;
  localparam int WSTW = WTTW + TIME_W;
  localparam int RW   = (WSTW + 1) / 2;
  localparam int DCW  = $clog2(WSTW + 1);
  localparam logic [WSTW-1:0] NUM_ALIGNED = WSTW'(WEIGHT_NUM) << (WSTW - WEIGHT_W);

  // captured item
  logic                cap_op;
  logic [TIME_W-1:0]   cap_t;
  logic [15:0]         cap_tries;
  logic                tries_big;

  // ring storage
  ring_entry_t         ring [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid;
  ring_entry_t         rd_entry;
  logic                rd_hit;
  logic [SW-1:0]       slot;

  // totals and results
  logic [WTW-1:0]      wt;
  logic [WTTW-1:0]     wtt;
  logic [WSTW-1:0]     wst;
  logic [TIME_W-1:0]   mean_reg;
  logic [TIME_W-1:0]   dev_reg;

  logic [WEIGHT_W-1:0] old_w;
  logic [TIME_W-1:0]   old_t;
  logic [WEIGHT_W-1:0] new_w;

  // shared multiplier
  logic [TIME_W-1:0]   mul_a;
  logic [WTTW-1:0]     mul_b;
  logic                mul_en;
  logic [WSTW-1:0]     prod;
  logic [WSTW-1:0]     p;

  // divider and root
  logic                div_start;
  logic [WSTW-1:0]     div_dvd;
  logic [WTW-1:0]      div_dvs;
  logic [DCW-1:0]      div_steps;
  logic                div_busy;
  logic [WSTW-1:0]     div_q;
  logic [WSTW-1:0]     num;
  logic                sqrt_busy;
  logic [RW-1:0]       root;

  assign tries_big = (cap_tries > 16'(WEIGHT_NUM));
  assign num       = (wst >= p) ? (wst - p) : '0;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (op)
      DP_INIT_MUL: begin
        mul_a = cap_t;
        mul_b = WTTW'(cap_t);
      end
      DP_MUL_OLD1: begin
        mul_a = old_t;
        mul_b = WTTW'(old_w);
      end
      DP_MUL_OLD2: begin
        mul_a = old_t;
        mul_b = p[WTTW-1:0];
      end
      DP_MUL_NEW1: begin
        mul_a = cap_t;
        mul_b = WTTW'(new_w);
      end
      DP_MUL_NEW2: begin
        mul_a = cap_t;
        mul_b = p[WTTW-1:0];
      end
      DP_MUL_MEAN: begin
        mul_a = mean_reg;
        mul_b = wtt;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign prod = {{WTTW{1'b0}}, mul_a} * {{TIME_W{1'b0}}, mul_b};

  always_comb begin
    div_start = 1'b1;
    div_dvd   = NUM_ALIGNED;
    div_dvs   = WTW'(cap_tries[WEIGHT_W-1:0]);
    div_steps = DCW'(WEIGHT_W);
    unique case (op)
      DP_READ: begin
      end
      DP_DIV_MEAN: begin
        div_dvd   = {wtt, {TIME_W{1'b0}}};
        div_dvs   = wt;
        div_steps = DCW'(WTTW);
      end
      DP_DIV_VAR: begin
        div_dvd   = num;
        div_dvs   = wt - 1'b1;
        div_steps = DCW'(WSTW);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  wrmd_divider #(
    .NW (WSTW),
    .DW (WTW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .steps    (div_steps),
    .busy     (div_busy),
    .quotient (div_q)
  );

  wrmd_sqrt #(
    .XW (WSTW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (op == DP_SQRT),
    .radicand (div_q),
    .busy     (sqrt_busy),
    .root     (root)
  );

  // ring memory, single write port, registered read
  always_ff @(posedge clk) begin
    if (op == DP_INIT_WR) begin
      ring[0] <= '{rtt: cap_t, weight: WEIGHT_W'(1)};
    end else if (op == DP_ACC_SQ) begin
      ring[slot] <= '{rtt: cap_t, weight: new_w};
    end
    if (op == DP_READ) begin
      rd_entry <= ring[slot];
      rd_hit   <= valid[slot];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (op == DP_CAPTURE) begin
      cap_op    <= sample.op;
      cap_t     <= (|sample.time_rt[31:TIME_W]) ? TIME_MAX : sample.time_rt[TIME_W-1:0];
      cap_tries <= sample.attempts;
    end
    if (op == DP_NEW_W) begin
      old_w <= rd_hit ? rd_entry.weight : '0;
      old_t <= rd_hit ? rd_entry.rtt : '0;
      new_w <= tries_big ? WEIGHT_W'(1) : div_q[WEIGHT_W-1:0];
    end
    if (mul_en) begin
      p <= prod;
    end
    if (op == DP_OUTPUT) begin
      result <= '{mean_time: mean_reg, deviation: dev_reg};
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      slot     <= '0;
      wt       <= '0;
      wtt      <= '0;
      wst      <= '0;
      mean_reg <= '0;
      dev_reg  <= '0;
    end else begin
      unique case (op)
        DP_INIT_WR: begin
          valid    <= RING_DEPTH'(1);
          slot     <= '0;
          wt       <= WTW'(1);
          wtt      <= WTTW'(cap_t);
          wst      <= p;
          mean_reg <= cap_t;
          dev_reg  <= '0;
        end
        DP_MUL_OLD2: begin
          wtt <= wtt - p[WTTW-1:0];
        end
        DP_MUL_NEW1: begin
          wst <= wst - p;
          wt  <= wt - WTW'(old_w) + WTW'(new_w);
        end
        DP_MUL_NEW2: begin
          wtt <= wtt + p[WTTW-1:0];
        end
        DP_ACC_SQ: begin
          wst         <= wst + p;
          valid[slot] <= 1'b1;
          slot        <= (slot == SW'(RING_DEPTH - 1)) ? '0 : slot + 1'b1;
        end
        DP_SET_MEAN: begin
          if (wt == '0) begin
            mean_reg <= '0;
          end else begin
            mean_reg <= (|div_q[WSTW-1:TIME_W]) ? TIME_MAX : div_q[TIME_W-1:0];
          end
        end
        DP_DEV_ZERO: begin
          dev_reg <= '0;
        end
        DP_SET_DEV: begin
          dev_reg <= (|root[RW-1:TIME_W]) ? TIME_MAX : root[TIME_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign status = '{
    op_add:     (cap_op == OP_ADD),
    tries_zero: (cap_tries == '0),
    wt_gt1:     (wt > WTW'(1)),
    div_busy:   div_busy,
    sqrt_busy:  sqrt_busy
  };

endmodule

[rtl/core/wrmd_ctrl.sv]
// ----------------------------------------------------------------------------
// wrmd_ctrl
// sequencer that steps the datapath through one init or add per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrmd_ctrl
  import wrmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  input  logic       result_stall,
  input  dp_status_t status,
  output dp_op_t     op,
  output logic       sample_stall,
  output logic       result_valid
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INIT_WR,
    S_DIVW,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_MEAN,
    S_MEANW,
    S_PROD,
    S_NUM,
    S_VARW,
    S_SQW,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign sample_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op         = DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          op         = DP_CAPTURE;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!status.op_add) begin
          op         = DP_INIT_MUL;
          state_next = S_INIT_WR;
        end else if (status.tries_zero) begin
          state_next = S_DONE;
        end else begin
          op         = DP_READ;
          state_next = S_DIVW;
        end
      end
      S_INIT_WR: begin
        op         = DP_INIT_WR;
        state_next = S_DONE;
      end
      S_DIVW: begin
        if (!status.div_busy) begin
          op         = DP_NEW_W;
          state_next = S_M1;
        end
      end
      S_M1: begin
        op         = DP_MUL_OLD1;
        state_next = S_M2;
      end
      S_M2: begin
        op         = DP_MUL_OLD2;
        state_next = S_M3;
      end
      S_M3: begin
        op         = DP_MUL_NEW1;
        state_next = S_M4;
      end
      S_M4: begin
        op         = DP_MUL_NEW2;
        state_next = S_M5;
      end
      S_M5: begin
        op         = DP_ACC_SQ;
        state_next = S_MEAN;
      end
      S_MEAN: begin
        op         = DP_DIV_MEAN;
        state_next = S_MEANW;
      end
      S_MEANW: begin
        if (!status.div_busy) begin
          op         = DP_SET_MEAN;
          state_next = S_PROD;
        end
      end
      S_PROD: begin
        op         = DP_MUL_MEAN;
        state_next = S_NUM;
      end
      S_NUM: begin
        if (status.wt_gt1) begin
          op         = DP_DIV_VAR;
          state_next = S_VARW;
        end else begin
          op         = DP_DEV_ZERO;
          state_next = S_DONE;
        end
      end
      S_VARW: begin
        if (!status.div_busy) begin
          op         = DP_SQRT;
          state_next = S_SQW;
        end
      end
      S_SQW: begin
        if (!status.sqrt_busy) begin
          op         = DP_SET_DEV;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          op         = DP_OUTPUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == DP_OUTPUT) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/wrmd_checker.sv]
// ----------------------------------------------------------------------------
// wrmd_checker
// port-level checks of the rtt mean/deviation unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "weighted_rtt_mean_deviation_unit_defines.svh"

module wrmd_checker
  import wrmd_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_stall,
  input sample_t sample,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  logic sample_beat;

  assign sample_beat = sample_valid && !sample_stall && (sample.op == OP_INIT || sample.op == OP_ADD);

  // a stalled result beat holds
  `WRMD_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "result beat changed under stall")

  // one item at a time: a taken sample closes the input
  `WRMD_ASSERT_NEXT(a_one_item, sample_beat, sample_stall, "sample taken while an item was in work")

  // a new result appears only at the end of an item in work
  `WRMD_ASSERT_NOW(a_result_from_item, $rose(result_valid), $past(sample_stall), "result without an item")

  // the input reopens only together with a fresh result beat
  `WRMD_ASSERT_NOW(a_reopen_with_result, $fell(sample_stall), result_valid, "item ended without a result")

endmodule

bind weighted_rtt_mean_deviation_unit wrmd_checker u_wrmd_checker (.*);

[dv/tb_weighted_rtt_mean_deviation_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_rtt_mean_deviation_unit
// self-checking bench: a clocked driver feeds round-trip samples from a backlog
// queue, a clocked monitor compares every result beat against a cycle-free
// model of the weighted ring statistics, under several idle/stall mixes
// ----------------------------------------------------------------------------

module tb_weighted_rtt_mean_deviation_unit;
  import wrmd_pkg::*;

  localparam int RING_DEPTH     = RING_DEPTH_DEF;
  localparam int QUIET_LIMIT    = 4000;   // cycles with no beat on either side
  localparam int HOLDOFF_CYCLES = 500;    // long output hold-off to back up the input
  localparam int HOLDOFF_AT     = 40;     // result count that triggers the hold-off
  localparam int DRAIN_CYCLES   = 300;    // tail after the last result, > one full add
  localparam int PHASE_ITEMS    = 150;    // counted random samples per idle phase

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // block ports; the driven inputs are known from time zero
  logic    sample_valid = 1'b0;
  logic    sample_stall;
  sample_t sample       = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  // stimulus backlog and expected result beats
  sample_t sample_backlog [$];
  result_t expected_stats [$];

  // idle mix of the current phase, in percent
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned mismatch_count  = 0;
  int unsigned results_checked = 0;
  int unsigned holdoff_left    = 0;
  logic        holdoff_done    = 1'b0;
  int unsigned quiet_cycles    = 0;

  // model copy of the ring and its running sums
  logic [TIME_W-1:0]   rtt_ring    [RING_DEPTH];
  logic [WEIGHT_W-1:0] weight_ring [RING_DEPTH];
  int unsigned         ring_slot;
  logic [31:0]         weight_sum;
  logic [63:0]         weighted_rtt_sum;
  logic [63:0]         weighted_sq_sum;
  logic [15:0]         mean_q;
  logic [15:0]         dev_q;

  weighted_rtt_mean_deviation_unit #(
    .RING_DEPTH (RING_DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // floor square root, one result bit per step from the top down
  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if ({32'd0, trial} * {32'd0, trial} <= x) root = trial;
    end
    return {32'd0, root};
  endfunction

  // advance the ring statistics by one sample, return the mean/deviation beat
  function automatic result_t rtt_stats_update(input sample_t s);
    logic [TIME_W-1:0] t;
    logic [63:0]       new_w;
    logic [63:0]       old_w;
    logic [63:0]       old_t;
    logic [63:0]       quot;
    logic [63:0]       prod;
    logic [63:0]       spread;
    logic [63:0]       root;
    result_t           beat;
    // times above 16 bits clip to the top value
    t = (s.time_rt > {16'd0, TIME_MAX}) ? TIME_MAX : s.time_rt[TIME_W-1:0];
    if (s.op == OP_INIT) begin
      // restart: empty ring, seed slot 0 with unit weight
      for (int k = 0; k < RING_DEPTH; k++) begin
        rtt_ring[k]    = '0;
        weight_ring[k] = '0;
      end
      ring_slot        = 0;
      rtt_ring[0]      = t;
      weight_ring[0]   = 1;
      weight_sum       = 1;
      weighted_rtt_sum = {48'd0, t};
      weighted_sq_sum  = {48'd0, t} * {48'd0, t};
      mean_q           = t;
      dev_q            = '0;
    end else if (s.attempts != 0) begin
      new_w = 64'(WEIGHT_NUM) / {48'd0, s.attempts};
      if (new_w == 0) new_w = 1;
      // evict the oldest entry
      old_w = {54'd0, weight_ring[ring_slot]};
      old_t = {48'd0, rtt_ring[ring_slot]};
      weighted_rtt_sum -= old_w * old_t;
      weighted_sq_sum  -= old_w * old_t * old_t;
      weight_sum       -= old_w[31:0];
      rtt_ring[ring_slot]    = t;
      weight_ring[ring_slot] = new_w[WEIGHT_W-1:0];
      weighted_rtt_sum += new_w * {48'd0, t};
      weighted_sq_sum  += new_w * {48'd0, t} * {48'd0, t};
      weight_sum       += new_w[31:0];
      if (weight_sum != 0) begin
        quot   = weighted_rtt_sum / {32'd0, weight_sum};
        mean_q = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
      end else begin
        mean_q = '0;
      end
      // sample variance needs more than one unit of weight
      if (weight_sum > 1) begin
        prod   = {48'd0, mean_q} * weighted_rtt_sum;
        spread = (weighted_sq_sum >= prod) ? weighted_sq_sum - prod : 64'd0;
        root   = floor_root(spread / {32'd0, weight_sum - 32'd1});
        dev_q  = (root > 64'hFFFF) ? 16'hFFFF : root[15:0];
      end else begin
        dev_q = '0;
      end
      ring_slot = (ring_slot + 1) % RING_DEPTH;
    end
    beat.mean_time = mean_q;
    beat.deviation = dev_q;
    return beat;
  endfunction

  // driver: one beat in flight, held steady while stalled
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      // beat taken at this edge: predict its result
      if (sample_valid && sample_stall === 1'b0) begin
        expected_stats.push_back(rtt_stats_update(sample));
      end
      // free to present the next beat, or to idle
      if (!sample_valid || sample_stall === 1'b0) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample       <= sample_backlog.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result beat, drive receiver stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid === 1'b1 && !result_stall) begin
        results_checked <= results_checked + 1;
        if (expected_stats.size() == 0) begin
          $error("result beat with no expected result pending");
          mismatch_count++;
        end else begin
          result_t want;
          want = expected_stats.pop_front();
          if (result.mean_time !== want.mean_time) begin
            $error("mean_time: expected %0d, actual %0d", want.mean_time, result.mean_time);
            mismatch_count++;
          end
          if (result.deviation !== want.deviation) begin
            $error("deviation: expected %0d, actual %0d", want.deviation, result.deviation);
            mismatch_count++;
          end
        end
      end
      // one long hold-off so the block fills and stalls its input
      if (holdoff_left != 0) begin
        result_stall <= 1'b1;
        holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && results_checked == HOLDOFF_AT) begin
        result_stall <= 1'b1;
        holdoff_left <= HOLDOFF_CYCLES;
        holdoff_done <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog: no beat on either channel for too long
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_stall === 1'b0) ||
        (result_valid === 1'b1 && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_add(input logic [31:0] t, input logic [15:0] tries);
    sample_t s;
    s.op       = OP_ADD;
    s.time_rt  = t;
    s.attempts = tries;
    sample_backlog.push_back(s);
  endtask

  // init ignores attempts, so random bits ride along
  task automatic queue_init(input logic [31:0] t);
    sample_t s;
    s.op       = OP_INIT;
    s.time_rt  = t;
    s.attempts = 16'($urandom());
    sample_backlog.push_back(s);
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(7))
      0:       return $urandom();                             // any 32-bit value
      1:       return $urandom_range(32'h0001_00FF, 32'h0000_FF00); // around the clip
      2:       return $urandom_range(255);
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic logic [15:0] pick_attempts();
    case ($urandom_range(9))
      0:       return 16'($urandom_range(65535, 1));
      1:       return 16'($urandom_range(1100, 900));  // weight floor boundary
      2:       return 16'($urandom_range(100, 9));
      default: return 16'($urandom_range(8, 1));
    endcase
  endfunction

  // mostly init followed by a run of adds around a base time; some runs skip
  // the init, some wrap the ring, a few zero-attempt adds slip in as noise
  task automatic queue_random_phase(input int unsigned target);
    int unsigned counted;
    int unsigned run_len;
    logic [31:0] base;
    logic [31:0] jmask;
    counted = 0;
    while (counted < target) begin
      base = pick_time();
      case ($urandom_range(3))
        0:       jmask = 32'h0;
        1:       jmask = 32'hF;
        2:       jmask = 32'hFF;
        default: jmask = 32'hFFF;
      endcase
      if ($urandom_range(9) < 8) begin
        queue_init(base ^ ($urandom() & jmask));
        counted++;
      end
      run_len = ($urandom_range(9) < 6) ? $urandom_range(30, 1) : $urandom_range(160, 60);
      repeat (run_len) begin
        if ($urandom_range(19) == 0) begin
          queue_add(pick_time(), 16'd0);
        end else begin
          queue_add(($urandom_range(9) == 0) ? pick_time() : base ^ ($urandom() & jmask),
                    pick_attempts());
          counted++;
        end
      end
    end
  endtask

  initial begin
    for (int k = 0; k < RING_DEPTH; k++) begin
      rtt_ring[k]    = '0;
      weight_ring[k] = '0;
    end
    ring_slot        = 0;
    weight_sum       = '0;
    weighted_rtt_sum = '0;
    weighted_sq_sum  = '0;
    mean_q           = '0;
    dev_q            = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: zero-attempt add straight after reset repeats zeros
    queue_add(32'd100, 16'd0);
    // adds before any init, full weight then floor weight with clipped time
    queue_add(32'd500, 16'd1);
    queue_add(32'hFFFF_FFFF, 16'hFFFF);
    // init with a clipped time, then a floor-weight add over the seed
    // leaves a single unit of weight
    queue_init(32'hFFFF_FFFF);
    queue_add(32'd70000, 16'd2000);
    queue_add(32'd65535, 16'd1);
    queue_add(32'd65536, 16'd1023);
    queue_add(32'd0, 16'd1024);
    queue_add(32'd0, 16'd0);
    // init at zero, then the widest spread of times
    queue_init(32'd0);
    queue_add(32'd0, 16'd1);
    queue_add(32'd65535, 16'd1);
    queue_add(32'd65534, 16'd2);
    // alternating bit patterns in the time and attempt fields
    queue_init(32'hAAAA_5555);
    queue_add(32'h5555_AAAA, 16'hAAAA);
    queue_add(32'h0000_AAAA, 16'h5555);
    queue_add(32'h0000_5555, 16'd3);
    queue_init(32'h0000_FFFE);
    queue_add(32'd1, 16'd511);
    queue_add(32'd2, 16'd512);

    // idle phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      queue_random_phase(PHASE_ITEMS);
      while (sample_backlog.size() != 0 || sample_valid) @(negedge clk);
    end

    // drain outstanding results, then a tail for stray beats
    while (expected_stats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_stats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/wrmd_pkg.sv
rtl/core/wrmd_divider.sv
rtl/core/wrmd_sqrt.sv
rtl/core/wrmd_datapath.sv
rtl/core/wrmd_ctrl.sv
rtl/core/weighted_rtt_mean_deviation_unit.sv
rtl/core/wrmd_checker.sv
dv/tb_weighted_rtt_mean_deviation_unit.sv
